[rtl/core/cdd_pkg.sv]
// Package for the calendar date difference unit: widths, stage types and month table.
`timescale 1ns / 1ps
`default_nettype none
package cdd_pkg;

	localparam int DAY_W   = 5;
	localparam int MONTH_W = 4;
	localparam int YEAR_W  = 14;
	localparam int DNUM_W  = 22;   // day number since 0001-01-01, up to 3652058
	localparam int DIFF_W  = 23;
	localparam int Q100_W  = 7;    // (year - 1) / 100, up to 99
	localparam int DBM_W   = 9;    // days before month, up to 334

	localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
	localparam logic [MONTH_W-1:0] MONTH_MAX = 4'd12;
	localparam logic [DNUM_W-1:0]  DNUM_MAX  = 22'd3652058;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x below 43699
	localparam int RECIP_W     = 13;
	localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = YEAR_W + RECIP_W;

	localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
	localparam logic [6:0] CENTURY_LAST  = 7'd99;

	// Per-date values carried from the product stage to the sum stage
	typedef struct packed {
		logic [DNUM_W-1:0] py365;     // (year - 1) * 365
		logic [YEAR_W-1:0] py;        // year - 1
		logic [Q100_W-1:0] q100;      // (year - 1) / 100
		logic [DBM_W-1:0]  dbm;       // days before the month, common year
		logic              past_feb;  // month after February
		logic [DAY_W-1:0]  dm1;       // day of month - 1
	} prep_t;

	// Days before the first of a month in a common year, index 0 is January
	function automatic logic [DBM_W-1:0] days_before_month(input logic [3:0] idx);
		logic [DBM_W-1:0] r;
		case (idx)
			4'd0:    r = 9'd0;
			4'd1:    r = 9'd31;
			4'd2:    r = 9'd59;
			4'd3:    r = 9'd90;
			4'd4:    r = 9'd120;
			4'd5:    r = 9'd151;
			4'd6:    r = 9'd181;
			4'd7:    r = 9'd212;
			4'd8:    r = 9'd243;
			4'd9:    r = 9'd273;
			4'd10:   r = 9'd304;
			4'd11:   r = 9'd334;
			default: r = 9'd334;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

[rtl/core/calendar_date_difference_unit.sv]
// Top level of the calendar date difference unit: four-register pipeline and handshake.
`timescale 1ns / 1ps
`default_nettype none
// Gives the signed number of days from a first Gregorian date to a second one,
// plus one when include_end_day is set. Each date is turned into a day number
// (0001-01-01 is day 0) by closed-form arithmetic: constant products, a
// reciprocal multiply for the division by 100 and a month table. The unit takes
// one item per cycle while item_stall is low; an item passes four registers
// (input register, product register, day-number register, result register)
// before result_valid rises for it. Every stage advances on its own when the
// next one is empty or moving, so bubbles close up and input is taken while a
// result waits, as long as some stage is free. Out-of-range codes are clamped:
// day 0 counts as 1, month 0 as January, months above 12 as December, year 0 as
// 1, years above 9999 as 9999; a day past month end counts on from the first of
// the month.
module calendar_date_difference_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         item_valid,
	output logic                              item_stall,
	input  wire logic [cdd_pkg::DAY_W-1:0]    first_day,
	input  wire logic [cdd_pkg::MONTH_W-1:0]  first_month,
	input  wire logic [cdd_pkg::YEAR_W-1:0]   first_year,
	input  wire logic [cdd_pkg::DAY_W-1:0]    second_day,
	input  wire logic [cdd_pkg::MONTH_W-1:0]  second_month,
	input  wire logic [cdd_pkg::YEAR_W-1:0]   second_year,
	input  wire logic                         include_end_day,
	output logic                              result_valid,
	input  wire logic                         result_stall,
	output logic signed [cdd_pkg::DIFF_W-1:0] day_difference
);

	// stage valids
	logic vld_s1, vld_s2, vld_s3, vld_q;
	// per-stage advance enables
	logic rdy_s1, rdy_s2, rdy_s3, rdy_q;

	// stage 1: captured item
	logic [cdd_pkg::DAY_W-1:0]   fd_s1, sd_s1;
	logic [cdd_pkg::MONTH_W-1:0] fm_s1, sm_s1;
	logic [cdd_pkg::YEAR_W-1:0]  fy_s1, sy_s1;
	logic                        inc_s1;

	// stage 2: products
	cdd_pkg::prep_t prep_a, prep_b;
	cdd_pkg::prep_t prep_a_s2, prep_b_s2;
	logic           inc_s2;

	// stage 3: day numbers
	logic [cdd_pkg::DNUM_W-1:0] dnum_a, dnum_b;
	logic [cdd_pkg::DNUM_W-1:0] dnum_a_s3, dnum_b_s3;
	logic                       inc_s3;

	// result
	logic signed [cdd_pkg::DIFF_W-1:0] diff;
	logic signed [cdd_pkg::DIFF_W-1:0] diff_q;

	// A stage may load when it is empty or its content moves on this edge
	assign rdy_q  = !vld_q || !result_stall;
	assign rdy_s3 = !vld_s3 || rdy_q;
	assign rdy_s2 = !vld_s2 || rdy_s3;
	assign rdy_s1 = !vld_s1 || rdy_s2;

	assign item_stall     = !rdy_s1;
	assign result_valid   = vld_q;
	assign day_difference = diff_q;

	// Valid chain: advance a token when the downstream stage can take it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_q  <= 1'b0;
		end else begin
			if (rdy_s1) begin
				vld_s1 <= item_valid;
			end
			if (rdy_s2) begin
				vld_s2 <= vld_s1;
			end
			if (rdy_s3) begin
				vld_s3 <= vld_s2;
			end
			if (rdy_q) begin
				vld_q <= vld_s3;
			end
		end
	end

	// Stage 1: hold the raw item
	always_ff @(posedge clk) begin
		if (rdy_s1 && item_valid) begin
			fd_s1  <= first_day;
			fm_s1  <= first_month;
			fy_s1  <= first_year;
			sd_s1  <= second_day;
			sm_s1  <= second_month;
			sy_s1  <= second_year;
			inc_s1 <= include_end_day;
		end
	end

	cdd_day_prep u_prep_a (
		.day   (fd_s1),
		.month (fm_s1),
		.year  (fy_s1),
		.prep  (prep_a)
	);

	cdd_day_prep u_prep_b (
		.day   (sd_s1),
		.month (sm_s1),
		.year  (sy_s1),
		.prep  (prep_b)
	);

	// Stage 2: register the products so no multiply feeds another
	always_ff @(posedge clk) begin
		if (rdy_s2 && vld_s1) begin
			prep_a_s2 <= prep_a;
			prep_b_s2 <= prep_b;
			inc_s2    <= inc_s1;
		end
	end

	cdd_day_sum u_sum_a (
		.prep (prep_a_s2),
		.dnum (dnum_a)
	);

	cdd_day_sum u_sum_b (
		.prep (prep_b_s2),
		.dnum (dnum_b)
	);

	// Stage 3: day numbers of both dates
	always_ff @(posedge clk) begin
		if (rdy_s3 && vld_s2) begin
			dnum_a_s3 <= dnum_a;
			dnum_b_s3 <= dnum_b;
			inc_s3    <= inc_s2;
		end
	end

	// Signed difference, plus one for an inclusive count
	assign diff = $signed({1'b0, dnum_b_s3}) - $signed({1'b0, dnum_a_s3})
		+ $signed({{(cdd_pkg::DIFF_W-1){1'b0}}, inc_s3});

	// Result register: hold while the consumer stalls
	always_ff @(posedge clk) begin
		if (rdy_q && vld_s3) begin
			diff_q <= diff;
		end
	end

`ifndef SYNTHESIS
	// Input is refused only when every stage holds an item
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		item_stall |-> (vld_s1 && vld_s2 && vld_s3 && vld_q))
		else $error("input stalled with a free pipeline stage");

	// An item leaving stage 3 shows up as a result on the next edge
	a_s3_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s3 && rdy_q) |=> result_valid)
		else $error("item lost between day-number stage and result");

	// An item leaving stage 2 lands in stage 3
	a_s2_to_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s2 && rdy_s3) |=> vld_s3)
		else $error("item lost between product stage and day-number stage");

	// Clamped dates never give a day number past 9999-12-31
	a_dnum_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (dnum_a_s3 <= cdd_pkg::DNUM_MAX && dnum_b_s3 <= cdd_pkg::DNUM_MAX))
		else $error("day number out of range");
`endif

endmodule
`default_nettype wire

[rtl/core/cdd_day_prep.sv]
// Date clamping, month table lookup and the constant products of one date.
`timescale 1ns / 1ps
`default_nettype none
module cdd_day_prep (
	input  wire logic [cdd_pkg::DAY_W-1:0]   day,
	input  wire logic [cdd_pkg::MONTH_W-1:0] month,
	input  wire logic [cdd_pkg::YEAR_W-1:0]  year,
	output cdd_pkg::prep_t                   prep
);

	logic [cdd_pkg::DAY_W-1:0]   d_c;
	logic [cdd_pkg::MONTH_W-1:0] m_c;
	logic [cdd_pkg::YEAR_W-1:0]  y_c;
	logic [cdd_pkg::YEAR_W-1:0]  py;
	logic [cdd_pkg::PROD_W-1:0]  recip_prod;
	logic [cdd_pkg::DNUM_W-1:0]  py365;

	always_comb begin
		// clamp out-of-range codes
		d_c = (day == '0) ? cdd_pkg::DAY_W'(1) : day;
		m_c = (month == '0) ? cdd_pkg::MONTH_W'(1) : month;
		if (m_c > cdd_pkg::MONTH_MAX) begin
			m_c = cdd_pkg::MONTH_MAX;
		end
		y_c = (year == '0) ? cdd_pkg::YEAR_W'(1) : year;
		if (y_c > cdd_pkg::YEAR_MAX) begin
			y_c = cdd_pkg::YEAR_MAX;
		end
		py = y_c - cdd_pkg::YEAR_W'(1);
	end

	assign recip_prod = cdd_pkg::PROD_W'(py) * cdd_pkg::PROD_W'(cdd_pkg::RECIP_100);
	assign py365      = cdd_pkg::DNUM_W'(py) * cdd_pkg::DNUM_W'(cdd_pkg::DAYS_PER_YEAR);

	always_comb begin
		prep.py365    = py365;
		prep.py       = py;
		prep.q100     = recip_prod[cdd_pkg::RECIP_SHIFT +: cdd_pkg::Q100_W];
		prep.dbm      = cdd_pkg::days_before_month(m_c - cdd_pkg::MONTH_W'(1));
		prep.past_feb = (m_c > cdd_pkg::MONTH_W'(2));
		prep.dm1      = d_c - cdd_pkg::DAY_W'(1);
	end

endmodule
`default_nettype wire

[rtl/core/cdd_day_sum.sv]
// Leap-year test and day-number sum of one date from its registered products.
`timescale 1ns / 1ps
`default_nettype none
module cdd_day_sum (
	input  wire cdd_pkg::prep_t             prep,
	output logic [cdd_pkg::DNUM_W-1:0]      dnum
);

	logic [cdd_pkg::YEAR_W-1:0] q_x100;
	logic [cdd_pkg::YEAR_W-1:0] rem100;
	logic                       div4;
	logic                       div100;
	logic                       div400;
	logic                       leap;

	// q * 100 as shifts and adds
	assign q_x100 = (cdd_pkg::YEAR_W'(prep.q100) << 6) + (cdd_pkg::YEAR_W'(prep.q100) << 5)
		+ (cdd_pkg::YEAR_W'(prep.q100) << 2);
	assign rem100 = prep.py - q_x100;

	// year = py + 1: tests shift by one against the year - 1 value
	assign div4   = (prep.py[1:0] == 2'b11);
	assign div100 = (rem100 == cdd_pkg::YEAR_W'(cdd_pkg::CENTURY_LAST));
	assign div400 = div100 && (prep.q100[1:0] == 2'b11);
	assign leap   = (div4 && !div100) || div400;

	assign dnum = prep.py365
		+ cdd_pkg::DNUM_W'(prep.py >> 2)
		- cdd_pkg::DNUM_W'(prep.q100)
		+ cdd_pkg::DNUM_W'(prep.q100 >> 2)
		+ cdd_pkg::DNUM_W'(prep.dbm)
		+ cdd_pkg::DNUM_W'(prep.past_feb && leap)
		+ cdd_pkg::DNUM_W'(prep.dm1);

endmodule
`default_nettype wire
